@@ src/pnc_pkg.sv @@
// pnc_pkg: command codes and shared types of the pn replica counter
`timescale 1ns / 1ps

package pnc_pkg;

	typedef logic [1:0] cmd_t;

	localparam cmd_t CMD_INC     = 2'd0;
	localparam cmd_t CMD_DEC     = 2'd1;
	localparam cmd_t CMD_MERGE   = 2'd2;
	localparam cmd_t CMD_COMPARE = 2'd3;

	// widths of the fixed fields
	localparam int IDX_W   = 4;
	localparam int FIELD_W = 32;

	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [FIELD_W-1:0] field_t;

endpackage

@@ src/pnc_ram.sv @@
// pnc_ram: generic single write port ram with registered read
`timescale 1ns / 1ps

module pnc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/pn_replica_counter.sv @@
// pn_replica_counter: one replica of a positive-negative counter
`timescale 1ns / 1ps
//
// Usage
//   A word is taken at a rising edge with start high and busy low. Command
//   increment or decrement adds amount to this replica's own entry (selected
//   by the replica_id register, written through cfg_wr_en / cfg_wr_data; the
//   user must write it only while idle, the block does not enforce this). Merge
//   takes the larger of local and remote counts for entry replica_index;
//   compare checks local <= remote and answers on the word with last_entry set.
//   Each word produces exactly one result word: total, compare_done and
//   compare_le, shown for one cycle with result_valid high. The receiver
//   cannot stall, so results are never held.
//   Sequence: the accepting edge launches the read of the entry pair from the
//   count rams. In the next cycle busy is high while the pair is modified;
//   the edge that ends it writes the pair back and loads the result registers
//   that drive the ports. The block takes no new word while busy is high, a
//   limit set by the read-modify-write of the rams.
//   Reset clears the running total, the compare flag, replica_id and the
//   per-entry valid bits; an entry that is not valid reads as zero, so no
//   clearing pass is needed and the block is ready right after reset.

module pn_replica_counter #(
	parameter int NREPLICAS   = 16,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  pnc_pkg::idx_t        cfg_wr_data,
	input  logic                 start,
	output logic                 busy,
	input  pnc_pkg::cmd_t        command,
	input  pnc_pkg::field_t      amount,
	input  pnc_pkg::idx_t        replica_index,
	input  pnc_pkg::field_t      remote_positive,
	input  pnc_pkg::field_t      remote_negative,
	input  logic                 last_entry,
	output logic                 result_valid,
	output logic signed [31:0]   total,
	output logic                 compare_done,
	output logic                 compare_le
);

	import pnc_pkg::*;

	localparam int AW = $clog2(NREPLICAS > 1 ? NREPLICAS : 2);
	localparam int CW = COUNT_WIDTH;
	localparam logic [8:0] NREP_W = 9'(NREPLICAS);

	logic [IDX_W-1:0] replica_id_q;

	// stage 1: word held while the ram read completes
	logic          valid_s1;
	cmd_t          cmd_s1;
	logic [CW-1:0] amt_s1;
	logic [CW-1:0] rp_s1;
	logic [CW-1:0] rn_s1;
	logic [AW-1:0] addr_s1;
	logic          hit_s1;
	logic          last_s1;

	logic [CW-1:0] total_q;
	logic          ok_q;
	logic          done_q;
	logic          le_q;
	logic          rvalid_q;
	logic [NREPLICAS-1:0] entry_valid_q;

	logic          accept;
	idx_t          sel_idx;
	logic [7:0]    sel_wide;
	logic [AW-1:0] rd_addr;
	logic          sel_hit;
	logic [CW-1:0] pos_rd;
	logic [CW-1:0] neg_rd;
	logic [CW-1:0] pos_old;
	logic [CW-1:0] neg_old;
	logic [CW-1:0] pos_new;
	logic [CW-1:0] neg_new;
	logic [CW-1:0] total_new;
	logic          wr_en;
	logic          fail;

	assign accept = start && !busy;
	assign busy   = valid_s1;

	// own entry for local updates, remote entry for merge and compare
	assign sel_idx  = (command == CMD_INC || command == CMD_DEC) ? replica_id_q : replica_index;
	assign sel_wide = {4'b0, sel_idx};
	assign rd_addr  = sel_wide[AW-1:0];
	assign sel_hit  = {1'b0, sel_wide} < NREP_W;

	pnc_ram #(.WIDTH(CW), .DEPTH(NREPLICAS)) u_pos_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_s1),
		.wdata (pos_new),
		.raddr (rd_addr),
		.rdata (pos_rd)
	);

	pnc_ram #(.WIDTH(CW), .DEPTH(NREPLICAS)) u_neg_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_s1),
		.wdata (neg_new),
		.raddr (rd_addr),
		.rdata (neg_rd)
	);

	assign pos_old = entry_valid_q[addr_s1] ? pos_rd : '0;
	assign neg_old = entry_valid_q[addr_s1] ? neg_rd : '0;

	always_comb begin
		pos_new   = pos_old;
		neg_new   = neg_old;
		total_new = total_q;
		wr_en     = 1'b0;
		fail      = 1'b0;
		unique case (cmd_s1)
			CMD_INC: begin
				pos_new   = pos_old + amt_s1;
				total_new = total_q + amt_s1;
				wr_en     = valid_s1 && hit_s1;
			end
			CMD_DEC: begin
				neg_new   = neg_old + amt_s1;
				total_new = total_q - amt_s1;
				wr_en     = valid_s1 && hit_s1;
			end
			CMD_MERGE: begin
				pos_new   = (rp_s1 > pos_old) ? rp_s1 : pos_old;
				neg_new   = (rn_s1 > neg_old) ? rn_s1 : neg_old;
				total_new = total_q + (pos_new - pos_old) - (neg_new - neg_old);
				wr_en     = valid_s1 && hit_s1;
			end
			CMD_COMPARE: begin
				fail = hit_s1 && ((pos_old > rp_s1) || (neg_old > rn_s1));
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
		// an entry outside the replica range leaves the total alone
		if (!hit_s1) begin
			total_new = total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			replica_id_q <= '0;
		end else if (cfg_wr_en) begin
			replica_id_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= command;
			amt_s1  <= CW'({{CW{1'b0}}, amount});
			rp_s1   <= CW'({{CW{1'b0}}, remote_positive});
			rn_s1   <= CW'({{CW{1'b0}}, remote_negative});
			addr_s1 <= rd_addr;
			hit_s1  <= sel_hit;
			last_s1 <= last_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q       <= '0;
			ok_q          <= 1'b1;
			done_q        <= 1'b0;
			le_q          <= 1'b0;
			rvalid_q      <= 1'b0;
			entry_valid_q <= '0;
		end else begin
			rvalid_q <= valid_s1;
			done_q   <= 1'b0;
			le_q     <= 1'b0;
			if (valid_s1) begin
				total_q <= total_new;
				if (wr_en) begin
					entry_valid_q[addr_s1] <= 1'b1;
				end
				if (cmd_s1 == CMD_COMPARE) begin
					if (last_s1) begin
						done_q <= 1'b1;
						le_q   <= ok_q && !fail;
						ok_q   <= 1'b1;
					end else begin
						ok_q <= ok_q && !fail;
					end
				end
			end
		end
	end

	assign result_valid = rvalid_q;
	assign total        = 32'({{32{1'b0}}, total_q});
	assign compare_done = done_q;
	assign compare_le   = le_q;

endmodule

@@ src/pnc_checker.sv @@
// pnc_checker: port-level assertions for the pn replica counter, bound to the top level
`timescale 1ns / 1ps

module pnc_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic result_valid,
	input logic compare_done,
	input logic compare_le
);

	// an accepted word occupies the block: busy rises in the next cycle and falls as the result appears
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	assert property (@(posedge clk) disable iff (!arst_n) busy |=> (!busy && result_valid))
		else $error("busy word did not deliver a result next cycle");

	// no result without a word in flight
	assert property (@(posedge clk) disable iff (!arst_n) result_valid |-> $past(busy))
		else $error("result without a preceding busy cycle");

	assert property (@(posedge clk) disable iff (!arst_n)
		(compare_done || compare_le) |-> result_valid)
		else $error("compare flags outside a result");

	assert property (@(posedge clk) disable iff (!arst_n) compare_le |-> compare_done)
		else $error("compare_le set on a word that ended no run");

endmodule

bind pn_replica_counter pnc_checker u_pnc_checker (.*);

@@ tb/sv/pn_replica_counter_test.sv @@
// pn_replica_counter_test: self-checking testbench for the pn replica counter
`timescale 1ns / 1ps

module pn_replica_counter_test;
	import pnc_pkg::*;

	localparam int NREP       = 16;
	localparam int IDLE_LIMIT = 1000;
	localparam int PHASE_WORDS = 280;

	typedef struct packed {
		cmd_t   command;
		field_t amount;
		idx_t   index;
		field_t rpos;
		field_t rneg;
		logic   last_mark;
	} word_t;

	typedef struct packed {
		logic [31:0] total;
		logic        done;
		logic        le;
	} report_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            cfg_wr_en = 1'b0;
	idx_t            cfg_wr_data = '0;
	logic            start = 1'b0;
	logic            busy;
	cmd_t            command = CMD_INC;
	field_t          amount = '0;
	idx_t            replica_index = '0;
	field_t          remote_positive = '0;
	field_t          remote_negative = '0;
	logic            last_entry = 1'b0;
	logic            result_valid;
	logic signed [31:0] total;
	logic            compare_done;
	logic            compare_le;

	// predicted replica state
	field_t  pos_count [NREP];
	field_t  neg_count [NREP];
	field_t  counter_value;
	logic    run_clean;
	idx_t    own_id;

	word_t   word_queue[$];
	report_t due_reports[$];
	word_t   cur_word;
	report_t want;
	int      burst_left = 1;
	int      gap_left = 0;
	int      mismatches = 0;
	int      idle_cycles = 0;

	pn_replica_counter u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.start           (start),
		.busy            (busy),
		.command         (command),
		.amount          (amount),
		.replica_index   (replica_index),
		.remote_positive (remote_positive),
		.remote_negative (remote_negative),
		.last_entry      (last_entry),
		.result_valid    (result_valid),
		.total           (total),
		.compare_done    (compare_done),
		.compare_le      (compare_le)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic report_t apply_word(input word_t w);
		report_t r;
		field_t  op, on, np, nn;
		r = '0;
		case (w.command)
			CMD_INC: begin
				pos_count[own_id] = pos_count[own_id] + w.amount;
				counter_value = counter_value + w.amount;
			end
			CMD_DEC: begin
				neg_count[own_id] = neg_count[own_id] + w.amount;
				counter_value = counter_value - w.amount;
			end
			CMD_MERGE: begin
				op = pos_count[w.index];
				on = neg_count[w.index];
				np = (w.rpos > op) ? w.rpos : op;
				nn = (w.rneg > on) ? w.rneg : on;
				pos_count[w.index] = np;
				neg_count[w.index] = nn;
				counter_value = counter_value + (np - op) - (nn - on);
			end
			CMD_COMPARE: begin
				if (pos_count[w.index] > w.rpos || neg_count[w.index] > w.rneg)
					run_clean = 1'b0;
				if (w.last_mark) begin
					r.done = 1'b1;
					r.le = run_clean;
					run_clean = 1'b1;
				end
			end
		endcase
		r.total = counter_value;
		return r;
	endfunction

	// driver: bursts of words with random gaps, start held until taken
	always @(posedge clk) begin
		if (start && !busy)
			due_reports.push_back(apply_word(cur_word));
		if (!(start && busy)) begin
			if (gap_left != 0 || word_queue.size() == 0) begin
				start <= 1'b0;
				if (gap_left != 0)
					gap_left--;
			end else begin
				cur_word = word_queue.pop_front();
				start <= 1'b1;
				command <= cur_word.command;
				amount <= cur_word.amount;
				replica_index <= cur_word.index;
				remote_positive <= cur_word.rpos;
				remote_negative <= cur_word.rneg;
				last_entry <= cur_word.last_mark;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left--;
				end
			end
		end
	end

	task automatic flag(input string what, input logic [31:0] exp_v, input logic [31:0] got_v);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s: expected %h, got %h", what, exp_v, got_v);
	endtask

	// monitor: every result word checked against the oldest prediction
	always @(posedge clk) begin
		if (result_valid) begin
			if (due_reports.size() == 0) begin
				flag("unexpected result word", 32'h0, total);
			end else begin
				want = due_reports.pop_front();
				if ($unsigned(total) !== want.total)
					flag("total", want.total, total);
				if (compare_done !== want.done)
					flag("compare_done", {31'b0, want.done}, {31'b0, compare_done});
				if (compare_le !== want.le)
					flag("compare_le", {31'b0, want.le}, {31'b0, compare_le});
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || result_valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic put(input cmd_t c, input field_t a, input idx_t i, input field_t rp,
			input field_t rn, input logic l);
		word_queue.push_back('{c, a, i, rp, rn, l});
	endtask

	function automatic field_t rand_count();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return $urandom_range(0, 255);
			3: return 32'hFFFF_FFFF - $urandom_range(0, 255);
			default: return $urandom;
		endcase
	endfunction

	function automatic word_t random_word();
		word_t w;
		w.command = cmd_t'($urandom_range(0, 3));
		w.amount = $urandom;
		w.index = idx_t'($urandom_range(0, NREP - 1));
		w.rpos = $urandom;
		w.rneg = $urandom;
		w.last_mark = 1'($urandom_range(0, 1));
		return w;
	endfunction

	task automatic add_random_words(input int n);
		word_t w;
		int    kind, len, pass_bias;
		int    made;
		made = 0;
		while (made < n) begin
			kind = $urandom_range(0, 99);
			if (kind < 30) begin
				w = random_word();
				w.command = $urandom_range(0, 1) ? CMD_INC : CMD_DEC;
				w.amount = rand_count();
				word_queue.push_back(w);
				made++;
			end else if (kind < 55) begin
				w = random_word();
				w.command = CMD_MERGE;
				w.rpos = rand_count();
				w.rneg = rand_count();
				word_queue.push_back(w);
				made++;
			end else if (kind < 90) begin
				// compare run, biased toward remote counts that dominate
				len = $urandom_range(1, 5);
				pass_bias = $urandom_range(0, 2);
				for (int k = 0; k < len; k++) begin
					if ($urandom_range(0, 7) == 0) begin
						w = random_word();
						w.command = CMD_INC;
						word_queue.push_back(w);
						made++;
					end
					w = random_word();
					w.command = CMD_COMPARE;
					w.rpos = (pass_bias != 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3) : rand_count();
					w.rneg = (pass_bias != 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3) : rand_count();
					w.last_mark = (k == len - 1);
					word_queue.push_back(w);
					made++;
				end
			end else begin
				word_queue.push_back(random_word());
				made++;
			end
		end
	endtask

	task automatic wait_drained();
		while (word_queue.size() != 0 || start || due_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_replica(input idx_t id);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= id;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		own_id = id;
	endtask

	initial begin
		idx_t ids [5];
		foreach (pos_count[k]) begin
			pos_count[k] = '0;
			neg_count[k] = '0;
		end
		counter_value = '0;
		run_clean = 1'b1;
		own_id = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words, own entry at its reset index
		put(CMD_INC,     32'h0,         4'd0,  32'h0,         32'h0,         1'b0);
		put(CMD_INC,     32'hFFFF_FFFF, 4'd7,  32'h0,         32'h0,         1'b0);
		put(CMD_INC,     32'h1,         4'd0,  32'h0,         32'h0,         1'b0);
		put(CMD_DEC,     32'hFFFF_FFFF, 4'd0,  32'h0,         32'h0,         1'b1);
		put(CMD_DEC,     32'h1,         4'd0,  32'h0,         32'h0,         1'b0);
		put(CMD_MERGE,   32'h0,         4'd3,  32'h1234_5678, 32'h0000_0042, 1'b0);
		// equal counts pass, non-compare word inside a run leaves it alone
		put(CMD_COMPARE, 32'h0,         4'd3,  32'h1234_5678, 32'h0000_0042, 1'b0);
		put(CMD_INC,     32'h5,         4'd3,  32'h0,         32'h0,         1'b1);
		put(CMD_COMPARE, 32'h0,         4'd3,  32'h1234_5678, 32'h0000_0042, 1'b1);
		put(CMD_COMPARE, 32'h0,         4'd0,  32'h0,         32'h0,         1'b1);
		put(CMD_COMPARE, 32'h0,         4'd3,  32'h0,         32'hFFFF_FFFF, 1'b0);
		put(CMD_COMPARE, 32'h0,         4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		put(CMD_COMPARE, 32'h0,         4'd15, 32'h0,         32'h0,         1'b1);
		put(CMD_MERGE,   32'h0,         4'd15, 32'hFFFF_FFFF, 32'h0,         1'b0);
		put(CMD_MERGE,   32'h0,         4'd15, 32'h10,        32'hFFFF_FFFF, 1'b1);
		put(CMD_MERGE,   32'h0,         4'd15, 32'h0,         32'h0,         1'b0);
		put(CMD_COMPARE, 32'h0,         4'd3,  32'h1234_5678, 32'h0,         1'b1);
		put(CMD_MERGE,   32'h0,         4'd0,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		put(CMD_DEC,     32'h0,         4'd0,  32'h0,         32'h0,         1'b0);
		put(CMD_COMPARE, 32'h0,         4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		wait_drained();

		ids = '{4'd15, 4'd0, 4'd9, idx_t'($urandom_range(0, NREP - 1)), 4'd15};
		foreach (ids[p]) begin
			set_replica(ids[p]);
			add_random_words(PHASE_WORDS);
			wait_drained();
		end

		if (mismatches == 0 && due_reports.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
